/* rtl/core/sqt_pkg.sv */
package sqt_pkg;

   // field widths
   localparam int LEN_W            = 6;
   localparam int CFG_W            = 6;
   localparam int KIND_W           = 4;
   localparam int WARN_W           = 5;
   localparam int BYTES_W          = 16;
   localparam int DEF_MAX_WORD_LEN = 32;
   localparam int FIFO_DEPTH       = 4;

   // token kinds
   localparam logic [KIND_W-1:0] K_WORD   = 4'd0;
   localparam logic [KIND_W-1:0] K_NOSTOP = 4'd1;
   localparam logic [KIND_W-1:0] K_EXCL   = 4'd2;
   localparam logic [KIND_W-1:0] K_OR     = 4'd3;
   localparam logic [KIND_W-1:0] K_AND    = 4'd4;
   localparam logic [KIND_W-1:0] K_PSTART = 4'd5;
   localparam logic [KIND_W-1:0] K_PEND   = 4'd6;
   localparam logic [KIND_W-1:0] K_MSTART = 4'd7;
   localparam logic [KIND_W-1:0] K_MEND   = 4'd8;
   localparam logic [KIND_W-1:0] K_SENT   = 4'd9;
   localparam logic [KIND_W-1:0] K_END    = 4'd10;

   // warning bits
   localparam logic [WARN_W-1:0] W_BOOL      = 5'd1;
   localparam logic [WARN_W-1:0] W_NEST      = 5'd2;
   localparam logic [WARN_W-1:0] W_UNMATCHED = 5'd4;
   localparam logic [WARN_W-1:0] W_QUOTES    = 5'd8;
   localparam logic [WARN_W-1:0] W_JUNK      = 5'd16;

   typedef enum logic [4:0] {
      S_TOP, S_WORD, S_WPUNC, S_NS, S_NSPUNC, S_EX, S_EXPUNC, S_OR, S_AND,
      S_PHR, S_PWORD, S_PWPUNC, S_ESENT, S_MODMOD, S_MOD, S_MWORD
   } parse_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_READ, B_SEND
   } back_state_type;

   // one emission command: a word or a single marker item (len 0 gives one item)
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [LEN_W-1:0]   len;
      logic [WARN_W-1:0]  warn;
      logic [BYTES_W-1:0] bytes;
   } cmd_type;

   // word store write
   typedef struct packed {
      logic             en;
      logic [LEN_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   // back end status
   typedef struct packed {
      logic done;
      logic active;
   } back_status_type;

endpackage

/* rtl/core/sqt_if.sv */
interface sqt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] query_byte;
   logic       end_of_query;

   modport source (output valid, output query_byte, output end_of_query, input ready);
   modport sink (input valid, input query_byte, input end_of_query, output ready);
endinterface

interface sqt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [7:0]  token_char;
   logic        char_valid;
   logic        last;
   logic [4:0]  warnings;
   logic [15:0] byte_count;

   modport source (output valid, output token_kind, output token_char, output char_valid,
                   output last, output warnings, output byte_count, input ready);
   modport sink (input valid, input token_kind, input token_char, input char_valid,
                 input last, input warnings, input byte_count, output ready);
endinterface

/* rtl/core/search_query_tokenizer.sv */
// channel   dir  handshake          payload
// req_chan  in   valid/ready        query_byte[8], end_of_query[1]
// rsp_chan  out  valid/ready        token_kind[4], token_char[8], char_valid, last,
//                                   warnings[5], byte_count[16]
// csr       in   csr_wr_en          csr_wr_data[6] = max_word_length
//
// a request is classified as it is accepted and leaves at most two commands in a
// four-entry queue; the back end fetches one command at a time, then for each
// result item reads the word store, then loads the output register, so a marker
// yields one item and a word of n characters n items; output stalls hold this.
// requests stall while a word with characters is still being read out, since
// the next word reuses the word store, while a second command waits to enter
// the queue, or while the queue is full.
// reset is synchronous; the word store has no clearing pass.
module search_query_tokenizer
   import sqt_pkg::*;
#(
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)(
   input  logic             clock,
   input  logic             reset,
   sqt_req_if.sink          req_chan,
   sqt_rsp_if.source        rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0] max_len_ff;
   logic             push, pop, fifo_full, fifo_empty;
   cmd_type          push_data, pop_data;
   wr_type           wr;
   back_status_type  back_status;

   // word limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= CFG_W'(DEF_MAX_WORD_LEN);
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   sqt_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .max_len   (max_len_ff),
      .fifo_full (fifo_full),
      .back_done (back_status.done),
      .push      (push),
      .push_data (push_data),
      .wr        (wr)
   );

   sqt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   sqt_back #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .pop        (pop),
      .rsp        (rsp_chan),
      .status     (back_status)
   );

   // word store is never written while a word is read out
   a_no_wr_during_read: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !back_status.active)
      else $error("word store written during readout");

   // queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!fifo_full || pop))
      else $error("queue push while full");

   // a finished word leaves its final item on the output
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      back_status.done |=> (rsp_chan.valid && rsp_chan.last && rsp_chan.char_valid))
      else $error("word end without final item");

endmodule

/* rtl/core/sqt_fifo.sv */
module sqt_fifo
   import sqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   localparam int PW = $clog2(FIFO_DEPTH);

   cmd_type         slot_ff [FIFO_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in;
   logic [PW-1:0]   rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wp_in  = push ? wp_ff + PW'(1) : wp_ff;
      rp_in  = pop ? rp_ff + PW'(1) : rp_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rp_ff];
   assign full     = (cnt_ff == (PW+1)'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);

endmodule

/* rtl/core/sqt_front.sv */
module sqt_front
   import sqt_pkg::*;
#(
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)(
   input  logic             clock,
   input  logic             reset,
   sqt_req_if.sink          req,
   input  logic [CFG_W-1:0] max_len,
   input  logic             fifo_full,
   input  logic             back_done,
   output logic             push,
   output cmd_type          push_data,
   output wr_type           wr
);

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_RBRK  = 8'h5D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_O     = 8'h4F;
   localparam logic [7:0] CH_R     = 8'h52;

   parse_state_type     state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [WARN_W-1:0]   warn_ff, warn_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic                pend_ff;
   cmd_type             pend_cmd_ff;
   logic                word_out_ff;

   logic [7:0]          b, ch;
   logic                up, low, dig, sp, ctl, ext, pun, alnum;
   logic [LEN_W-1:0]    lim;
   logic                fits;
   logic                accept;
   logic                wa, wforce, ma, has_w;
   logic [KIND_W-1:0]   wk, mk;
   logic [WARN_W-1:0]   post;
   logic [BYTES_W-1:0]  item_bytes;
   logic                op_hit;
   cmd_type             cw, cm, c0;

   assign accept    = req.valid && req.ready;
   assign req.ready = !pend_ff && !fifo_full && !word_out_ff;

   // byte classes
   always_comb begin
      b     = req.query_byte;
      up    = (b >= 8'h41) && (b <= 8'h5A);
      low   = (b >= 8'h61) && (b <= 8'h7A);
      dig   = (b >= 8'h30) && (b <= 8'h39);
      sp    = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
      ext   = b[7];
      ctl   = !sp && ((b < 8'h20) || (b == 8'h7F));
      pun   = !up && !low && !dig && !sp && !ctl && !ext;
      alnum = up || low || dig;
      ch    = up ? b + 8'd32 : b;
      lim   = (max_len > CFG_W'(MAX_WORD_LEN)) ? LEN_W'(MAX_WORD_LEN) : LEN_W'(max_len);
      fits  = len_ff < lim;
   end

   // operator letter match for AND / OR
   always_comb begin
      if (state_ff == S_OR) begin
         op_hit = ((len_ff == LEN_W'(0)) && (b == CH_O)) ||
                  ((len_ff == LEN_W'(1)) && (b == CH_R));
      end else begin
         op_hit = ((len_ff == LEN_W'(0)) && (b == CH_A)) ||
                  ((len_ff == LEN_W'(1)) && (b == CH_N)) ||
                  ((len_ff == LEN_W'(2)) && (b == CH_D));
      end
   end

   // tokenizer step
   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      warn_in  = warn_ff;
      wa       = 1'b0;
      wforce   = 1'b0;
      wk       = K_WORD;
      ma       = 1'b0;
      mk       = K_WORD;
      post     = '0;
      wr.en    = 1'b0;
      wr.addr  = len_ff;
      wr.data  = ch;
      has_w    = 1'b0;
      cw       = '0;
      cm       = '0;

      if (req.end_of_query) begin
         item_bytes = bytes_ff;
         unique case (state_ff)
            S_WORD, S_WPUNC, S_OR, S_AND: begin
               wa = 1'b1;
            end
            S_NS, S_NSPUNC: begin
               wa = 1'b1;
               wk = K_NOSTOP;
            end
            S_EX, S_EXPUNC: begin
               wa = 1'b1;
               wk = K_EXCL;
            end
            S_PHR: begin
               warn_in = warn_in | W_QUOTES;
            end
            S_PWORD, S_PWPUNC: begin
               warn_in = warn_in | W_QUOTES;
               wa      = 1'b1;
            end
            S_ESENT: begin
               wa   = 1'b1;
               post = W_QUOTES;
            end
            S_MODMOD, S_MWORD: begin
               warn_in = warn_in | W_UNMATCHED;
               wa      = 1'b1;
            end
            S_MOD: begin
               warn_in = warn_in | W_UNMATCHED;
            end
            default: begin
            end
         endcase
         ma = 1'b1;
         mk = K_END;
      end else begin
         item_bytes = (bytes_ff == '1) ? bytes_ff : bytes_ff + BYTES_W'(1);
         if (state_ff == S_ESENT && sp) begin
            wa       = 1'b1;
            ma       = 1'b1;
            mk       = K_SENT;
            state_in = S_PHR;
         end else begin
            if (state_ff == S_ESENT) begin
               state_in = S_PWORD;
            end
            unique case (state_in)
               S_OR, S_AND: begin
                  if (up) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                        if (!op_hit) state_in = S_WORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (low || dig) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = S_WORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (ctl || ext) begin
                     state_in = S_WORD;
                  end else if (sp) begin
                     if (len_ff == ((state_ff == S_OR) ? LEN_W'(2) : LEN_W'(3))) begin
                        ma       = 1'b1;
                        mk       = (state_ff == S_OR) ? K_OR : K_AND;
                        state_in = S_TOP;
                     end else begin
                        wa       = 1'b1;
                        state_in = S_TOP;
                     end
                  end else begin
                     state_in = S_WPUNC;
                  end
               end
               S_WORD: begin
                  if (alnum) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (sp) begin
                     wa       = 1'b1;
                     state_in = S_TOP;
                  end else if (pun) begin
                     state_in = S_WPUNC;
                  end
               end
               S_WPUNC: begin
                  if (alnum) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = S_WORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (pun) begin
                     wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                  end else if (sp) begin
                     wa       = 1'b1;
                     state_in = S_TOP;
                  end
               end
               S_NS, S_EX: begin
                  wk = (state_in == S_NS) ? K_NOSTOP : K_EXCL;
                  if (alnum) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (sp) begin
                     wa       = 1'b1;
                     state_in = S_TOP;
                  end else if (pun) begin
                     state_in = (state_ff == S_NS) ? S_NSPUNC : S_EXPUNC;
                  end
               end
               S_NSPUNC, S_EXPUNC: begin
                  wk = (state_in == S_NSPUNC) ? K_NOSTOP : K_EXCL;
                  if (alnum) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = (state_ff == S_NSPUNC) ? S_NS : S_EXPUNC;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (sp || pun) begin
                     wa       = 1'b1;
                     state_in = S_TOP;
                  end
               end
               S_PHR: begin
                  if (alnum) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = S_PWORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_PHR;
                     end
                  end else if (b == CH_QUOTE) begin
                     ma       = 1'b1;
                     mk       = K_PEND;
                     state_in = S_TOP;
                  end else if (!sp) begin
                     state_in = S_PWORD;
                  end
               end
               S_PWORD, S_PWPUNC: begin
                  if (alnum) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = S_PWORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_PHR;
                     end
                  end else if (b == CH_QUOTE) begin
                     wa       = 1'b1;
                     ma       = 1'b1;
                     mk       = K_PEND;
                     state_in = S_TOP;
                  end else if (b == CH_DOT || b == CH_BANG || b == CH_QUEST) begin
                     state_in = S_ESENT;
                  end else if (ctl || ext) begin
                  end else if (state_in == S_PWORD && b == CH_MINUS) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_PHR;
                     end
                  end else if (state_in == S_PWORD && pun) begin
                     state_in = S_PWPUNC;
                  end else begin
                     wa       = 1'b1;
                     state_in = (len_ff != '0) ? S_PHR : S_TOP;
                  end
               end
               S_MODMOD: begin
                  if (alnum || ext || b == CH_MINUS) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (b == CH_COLON) begin
                     wa = 1'b1; wforce = 1'b1; wk = K_MSTART; state_in = S_MOD;
                  end else begin
                     if (b == CH_LBRK) warn_in = warn_in | W_NEST;
                     wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                  end
               end
               S_MOD: begin
                  if (alnum || ext) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = S_MWORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_MOD;
                     end
                  end else if (b == CH_RBRK) begin
                     ma       = 1'b1;
                     mk       = K_MEND;
                     state_in = S_TOP;
                  end else if (!sp) begin
                     if (b == CH_LBRK) warn_in = warn_in | W_NEST;
                     state_in = S_MWORD;
                  end
               end
               S_MWORD: begin
                  if (alnum || b == CH_MINUS) begin
                     if (fits) begin
                        wr.en  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_MOD;
                     end
                  end else if (b == CH_RBRK) begin
                     wa       = 1'b1;
                     ma       = 1'b1;
                     mk       = K_MEND;
                     state_in = S_TOP;
                  end else if (b == CH_APOS) begin
                  end else begin
                     if (b == CH_LBRK) warn_in = warn_in | W_NEST;
                     wa       = 1'b1;
                     state_in = S_MOD;
                  end
               end
               default: begin
                  // top level
                  state_in = S_TOP;
                  if (alnum) begin
                     if (fits) begin
                        wr.en    = 1'b1;
                        len_in   = len_ff + LEN_W'(1);
                        state_in = (b == CH_A) ? S_AND : (b == CH_O) ? S_OR : S_WORD;
                     end else begin
                        wa = 1'b1; wforce = 1'b1; state_in = S_TOP;
                     end
                  end else if (b == CH_PLUS) begin
                     state_in = S_NS;
                  end else if (b == CH_MINUS) begin
                     state_in = S_EX;
                  end else if (b == CH_QUOTE) begin
                     ma       = 1'b1;
                     mk       = K_PSTART;
                     state_in = S_PHR;
                  end else if (b == CH_LBRK) begin
                     state_in = S_MODMOD;
                  end else if (!sp) begin
                     if (b == CH_LPAR) warn_in = warn_in | W_BOOL;
                     state_in = S_WORD;
                  end
               end
            endcase
         end
      end

      // word emission, then marker
      if (wa) begin
         if (len_ff != '0 || wforce) begin
            has_w   = 1'b1;
            cw      = '{kind: wk, len: len_ff, warn: warn_in, bytes: item_bytes};
            warn_in = '0;
            len_in  = '0;
         end else begin
            warn_in = warn_in | W_JUNK;
         end
      end
      warn_in = warn_in | post;
      if (ma) begin
         cm      = '{kind: mk, len: '0, warn: warn_in, bytes: item_bytes};
         warn_in = '0;
         len_in  = '0;
      end
      c0 = has_w ? cw : cm;

      bytes_in = item_bytes;
      if (req.end_of_query) begin
         state_in = S_TOP;
         len_in   = '0;
         bytes_in = '0;
      end

      if (!accept) begin
         wr.en = 1'b0;
      end
   end

   // queue write: first command now, a second one from the pending register once the queue has room
   assign push      = (accept && (has_w || ma)) || (pend_ff && !fifo_full);
   assign push_data = pend_ff ? pend_cmd_ff : c0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_TOP;
         len_ff      <= '0;
         warn_ff     <= '0;
         bytes_ff    <= '0;
         pend_ff     <= 1'b0;
         word_out_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            len_ff   <= len_in;
            warn_ff  <= warn_in;
            bytes_ff <= bytes_in;
         end
         if (accept && has_w && ma) begin
            pend_ff <= 1'b1;
         end else if (pend_ff && !fifo_full) begin
            pend_ff <= 1'b0;
         end
         if (accept && has_w && cw.len != '0) begin
            word_out_ff <= 1'b1;
         end else if (back_done) begin
            word_out_ff <= 1'b0;
         end
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      if (accept && has_w && ma) begin
         pend_cmd_ff <= cm;
      end
   end

endmodule

/* rtl/core/sqt_back.sv */
module sqt_back
   import sqt_pkg::*;
#(
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)(
   input  logic            clock,
   input  logic            reset,
   input  wr_type          wr,
   input  logic            fifo_empty,
   input  cmd_type         fifo_data,
   output logic            pop,
   sqt_rsp_if.source       rsp,
   output back_status_type status
);

   localparam int AW = $clog2(MAX_WORD_LEN);

   logic [7:0]       mem [MAX_WORD_LEN];
   logic [7:0]       rd_ff;
   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             out_free, load, is_last;
   logic             valid_ff;
   logic [3:0]       kind_ff;
   logic [7:0]       char_ff;
   logic             cv_ff, last_ff;
   logic [4:0]       warn_ff;
   logic [15:0]      bytes_ff;

   // word store
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   assign out_free = !valid_ff || rsp.ready;
   assign is_last  = (cmd_ff.len == '0) || (idx_ff + LEN_W'(1) == cmd_ff.len);

   // sequencer: fetch a command, then read and send one item per pass
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      load     = 1'b0;
      status   = '{done: 1'b0, active: (state_ff != B_IDLE) && (cmd_ff.len != '0)};
      unique case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               cmd_in   = fifo_data;
               idx_in   = '0;
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_SEND;
         end
         B_SEND: begin
            if (out_free) begin
               load = 1'b1;
               if (is_last) begin
                  status.done = (cmd_ff.len != '0);
                  state_in    = B_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // command and output payload
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (load) begin
         kind_ff  <= cmd_ff.kind;
         char_ff  <= (cmd_ff.len == '0) ? 8'd0 : rd_ff;
         cv_ff    <= (cmd_ff.len != '0);
         last_ff  <= is_last;
         warn_ff  <= cmd_ff.warn;
         bytes_ff <= cmd_ff.bytes;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.token_kind = kind_ff;
   assign rsp.token_char = char_ff;
   assign rsp.char_valid = cv_ff;
   assign rsp.last       = last_ff;
   assign rsp.warnings   = warn_ff;
   assign rsp.byte_count = bytes_ff;

endmodule
